FILE: hw/rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and codes for the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

	typedef logic [1:0] status_t;

	localparam status_t STATUS_OK       = 2'd0;
	localparam status_t STATUS_NO_SPACE = 2'd1;
	localparam status_t STATUS_BAD      = 2'd2;

	localparam int unsigned BLK_W   = 10;
	localparam int unsigned COUNT_W = 7;
	localparam int unsigned TOTAL_W = 11;

	localparam logic [TOTAL_W-1:0] TOTAL_RESET = 11'd1024;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_RECOUNT_RD,
		S_RECOUNT_CHK,
		S_ALLOC_RD,
		S_ALLOC_CHK,
		S_FREE_RD,
		S_FREE_CHK,
		S_RESP
	} bba_state_t;

endpackage

FILE: hw/rtl/bba_if.sv
// ----------------------------------------------------------------------------
// bba_if
// Valid/ready channels of the bitmap block allocator: request, result and
// configuration write.
// ----------------------------------------------------------------------------
interface bba_req_if;
	import bba_pkg::*;

	logic               valid;
	logic               ready;
	logic               func;
	logic [COUNT_W-1:0] count;
	logic [BLK_W-1:0]   block_number;

	modport source (output valid, output func, output count, output block_number,
		input ready);
	modport sink (input valid, input func, input count, input block_number,
		output ready);
endinterface

interface bba_rsp_if;
	import bba_pkg::*;

	logic               valid;
	logic               ready;
	logic [BLK_W-1:0]   block_number_out;
	status_t            status;
	logic               last;
	logic [TOTAL_W-1:0] free_left;

	modport source (output valid, output block_number_out, output status,
		output last, output free_left, input ready);
	modport sink (input valid, input block_number_out, input status,
		input last, input free_left, output ready);
endinterface

interface bba_cfg_if;
	import bba_pkg::*;

	logic               valid;
	logic               ready;
	logic [TOTAL_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/bba_ram.sv
// ----------------------------------------------------------------------------
// bba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hw/rtl/bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit block allocator over a used-block bitmap held in RAM.
// ----------------------------------------------------------------------------
// Channels: req carries func/count/block_number, rsp returns one beat per
// allocated block (last on the final one), or a single beat for a free or a
// failed request. cfg writes total_blocks; the bitmap is kept and the free
// count is recounted by a sweep that reads and then checks each managed block.
// The bitmap is read one bit per RAM access, a read then a check state per
// block inspected. An allocate scans from block 0 to the highest block it
// takes, a free inspects its own block only, a rejected request none; any
// rsp stall adds to each. req is not ready while a request or a recount is
// in progress. After reset a clearing pass writes every bitmap entry, during
// which req is held off; cfg writes are still taken.
// rsp has an output register: a stalled receiver holds the sequencer only
// when the next beat is ready to go.
// ----------------------------------------------------------------------------
module bitmap_block_allocator #(
	parameter int NUM_BLOCKS = 1024,
	parameter int MAX_RUN    = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	bba_req_if.sink  req,
	bba_rsp_if.source rsp,
	bba_cfg_if.sink  cfg
);
	import bba_pkg::*;

	localparam int AW = $clog2(NUM_BLOCKS);
	localparam int TW = (AW + 1 > TOTAL_W) ? AW + 1 : TOTAL_W;
	localparam logic [TW-1:0] NB       = TW'(NUM_BLOCKS);
	localparam logic [TW-1:0] LAST_IDX = TW'(NUM_BLOCKS - 1);
	localparam logic [TW-1:0] ONE      = TW'(1);

	function automatic logic [TW-1:0] eff_of(input logic [TOTAL_W-1:0] v);
		logic [TW-1:0] ext;
		ext = TW'(v);
		return (ext > NB) ? NB : ext;
	endfunction

	bba_state_t state_q, state_d;

	logic [TW-1:0]      idx_q, free_q, cnt_q, eff_q;
	logic [COUNT_W-1:0] k_q, req_cnt_q;
	status_t            resp_status_q;
	logic [BLK_W-1:0]   resp_blk_q;

	logic               rsp_valid_q;
	logic [BLK_W-1:0]   rsp_blk_q;
	status_t            rsp_status_q;
	logic               rsp_last_q;
	logic [TOTAL_W-1:0] rsp_free_q;

	logic cfg_fire, in_fire, slot_free, bit_used;
	logic count_bad, blk_bad, short_free;
	logic [TW-1:0] blk_ext;
	logic alloc_last;

	logic             ram_we, ram_wdata, ram_re;
	logic [0:0]       ram_rdata;
	logic             emit;
	logic [BLK_W-1:0] emit_blk;
	status_t          emit_status;
	logic             emit_last;
	logic [TW-1:0]    emit_free;

	assign cfg.ready = state_q inside {S_CLEAR, S_IDLE, S_RECOUNT_RD, S_RECOUNT_CHK};
	assign req.ready = (state_q == S_IDLE) && !cfg.valid;
	assign cfg_fire  = cfg.valid && cfg.ready;
	assign in_fire   = req.valid && req.ready;
	assign slot_free = !rsp_valid_q || rsp.ready;
	assign bit_used  = ram_rdata[0];

	assign blk_ext    = TW'(req.block_number);
	assign blk_bad    = blk_ext >= eff_q;
	assign count_bad  = (req.count == '0) || (req.count > COUNT_W'(MAX_RUN));
	assign short_free = free_q < TW'(req.count);
	assign alloc_last = (k_q + 1'b1) == req_cnt_q;

	bba_ram #(
		.WIDTH(1),
		.DEPTH(NUM_BLOCKS)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx_q[AW-1:0]),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(idx_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (idx_q == LAST_IDX) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (cfg_fire) begin
					state_d = S_RECOUNT_RD;
				end else if (in_fire) begin
					if (req.func) state_d = blk_bad ? S_RESP : S_FREE_RD;
					else if (count_bad || short_free) state_d = S_RESP;
					else state_d = S_ALLOC_RD;
				end
			end
			S_RECOUNT_RD: begin
				if (cfg_fire) state_d = S_RECOUNT_RD;
				else if (idx_q >= eff_q) state_d = S_IDLE;
				else state_d = S_RECOUNT_CHK;
			end
			S_RECOUNT_CHK: state_d = S_RECOUNT_RD;
			S_ALLOC_RD:    state_d = S_ALLOC_CHK;
			S_ALLOC_CHK: begin
				if (bit_used) state_d = S_ALLOC_RD;
				else if (slot_free) state_d = alloc_last ? S_IDLE : S_ALLOC_RD;
			end
			S_FREE_RD: state_d = S_FREE_CHK;
			S_FREE_CHK: begin
				if (slot_free) state_d = S_IDLE;
			end
			S_RESP: begin
				if (slot_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// RAM control and result beat
	always_comb begin
		ram_we      = 1'b0;
		ram_wdata   = 1'b0;
		ram_re      = 1'b0;
		emit        = 1'b0;
		emit_blk    = resp_blk_q;
		emit_status = resp_status_q;
		emit_last   = 1'b1;
		emit_free   = free_q;
		case (state_q)
			S_CLEAR: ram_we = 1'b1;
			S_RECOUNT_RD, S_ALLOC_RD, S_FREE_RD: ram_re = 1'b1;
			S_ALLOC_CHK: begin
				if (!bit_used && slot_free) begin
					ram_we    = 1'b1;
					ram_wdata = 1'b1;
					emit      = 1'b1;
				end
				emit_blk    = idx_q[BLK_W-1:0];
				emit_status = STATUS_OK;
				emit_last   = alloc_last;
				emit_free   = free_q - ONE;
			end
			S_FREE_CHK: begin
				ram_we      = slot_free && bit_used;
				emit        = slot_free;
				emit_status = STATUS_OK;
				emit_free   = free_q + TW'(bit_used);
			end
			S_RESP: emit = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			idx_q         <= '0;
			free_q        <= '0;
			cnt_q         <= '0;
			eff_q         <= eff_of(TOTAL_RESET);
			k_q           <= '0;
			req_cnt_q     <= '0;
			resp_status_q <= STATUS_OK;
			resp_blk_q    <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_fire) eff_q <= eff_of(cfg.data);
			case (state_q)
				S_CLEAR: begin
					idx_q <= idx_q + ONE;
					if (idx_q == LAST_IDX) free_q <= cfg_fire ? eff_of(cfg.data) : eff_q;
				end
				S_IDLE: begin
					if (cfg_fire) begin
						idx_q <= '0;
						cnt_q <= '0;
					end else if (in_fire) begin
						req_cnt_q  <= req.count;
						k_q        <= '0;
						idx_q      <= req.func ? blk_ext : '0;
						resp_blk_q <= req.func ? req.block_number : '0;
						if (req.func || count_bad) resp_status_q <= STATUS_BAD;
						else resp_status_q <= STATUS_NO_SPACE;
					end
				end
				S_RECOUNT_RD, S_RECOUNT_CHK: begin
					if (cfg_fire) begin
						idx_q <= '0;
						cnt_q <= '0;
					end else if (state_q == S_RECOUNT_CHK) begin
						cnt_q <= cnt_q + TW'(!bit_used);
						idx_q <= idx_q + ONE;
					end else if (idx_q >= eff_q) begin
						free_q <= cnt_q;
					end
				end
				S_ALLOC_CHK: begin
					if (bit_used) begin
						idx_q <= idx_q + ONE;
					end else if (slot_free) begin
						idx_q  <= idx_q + ONE;
						free_q <= free_q - ONE;
						k_q    <= k_q + 1'b1;
					end
				end
				S_FREE_CHK: begin
					if (slot_free && bit_used) free_q <= free_q + ONE;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_blk_q    <= emit_blk;
			rsp_status_q <= emit_status;
			rsp_last_q   <= emit_last;
			rsp_free_q   <= emit_free[TOTAL_W-1:0];
		end
	end

	assign rsp.valid            = rsp_valid_q;
	assign rsp.block_number_out = rsp_blk_q;
	assign rsp.status           = rsp_status_q;
	assign rsp.last             = rsp_last_q;
	assign rsp.free_left        = rsp_free_q;

endmodule

FILE: hw/rtl/bba_checker.sv
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks on the bitmap block allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bba_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      req_ready,
	input logic                      rsp_valid,
	input logic                      rsp_ready,
	input bba_pkg::status_t          rsp_status,
	input logic                      rsp_last,
	input logic [bba_pkg::BLK_W-1:0] rsp_block,
	input logic [bba_pkg::TOTAL_W-1:0] rsp_free
);
	import bba_pkg::*;

	// stalled beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_block) &&
		$stable(rsp_status) && $stable(rsp_last) && $stable(rsp_free))
	else $error("rsp beat changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != STATUS_OK) |-> rsp_last)
	else $error("failure beat without last");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == STATUS_NO_SPACE) |-> (rsp_block == '0))
	else $error("no-space beat carries a block number");

	// mid-run allocation: no new request may be taken
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == STATUS_OK) && !rsp_last |-> !req_ready)
	else $error("request accepted during an allocation run");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_status(rsp.status),
	.rsp_last  (rsp.last),
	.rsp_block (rsp.block_number_out),
	.rsp_free  (rsp.free_left)
);
